>>> rtl/core/rdip_pkg.sv
// Shared types and constants for the random draw index pool.
// Used by rdip_mod_unit and random_draw_index_pool_unit; depends on nothing.
`default_nettype none

package rdip_pkg;

   // coordinate, key, count, random and step widths; pool depth
   localparam int COORD_W    = 4;
   localparam int KEY_W      = 3 * COORD_W;
   localparam int POOL_DEPTH = 1 << KEY_W;
   localparam int COUNT_W    = KEY_W + 1;
   localparam int RAND_W     = 16;
   localparam int STEP_W     = 4;

   // grid size defaults
   localparam int DEF_ROW_COUNT   = 16;
   localparam int DEF_COL_COUNT   = 16;
   localparam int DEF_LAYER_COUNT = 16;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DRAW   = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_REFUSE = 2'd2;

   // modulo unit progress flags
   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

`default_nettype wire

>>> rtl/core/rdip_mod_unit.sv
// Iterative restoring modulo unit: random value mod live entry count.
// One quotient bit per cycle; depends on rdip_pkg.
`default_nettype none

module rdip_mod_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [rdip_pkg::RAND_W-1:0]   dividend,
   input  wire [rdip_pkg::COUNT_W-1:0]  divisor,
   output rdip_pkg::mod_status_type     status,
   output logic [rdip_pkg::KEY_W-1:0]   remainder
);
   import rdip_pkg::*;

   logic [KEY_W-1:0]   rem_ff, rem_in;
   logic [RAND_W-1:0]  quo_ff, quo_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] trial;
   logic [COUNT_W-1:0] diff;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[RAND_W-1]};
   assign diff  = trial - div_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = (trial >= div_ff) ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
         quo_in  = {quo_ff[RAND_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

>>> rtl/core/random_draw_index_pool_unit.sv
// Top level of the random draw index pool: slot store, reverse map, presence map.
// Depends on rdip_pkg and rdip_mod_unit.
//
//   channel | direction | handshake           | contents
//   req     | in        | req_tvalid/tready   | tuser: action; tdata: row, col, layer, random
//   rsp     | out       | rsp_tvalid/tready   | tuser: status; tdata: row, col, layer, remaining
//
// An insert, a refused item or an unused action goes from accept through probe
// and decide to the result, and a remove adds a take step; a draw waits for the
// 16-step modulo unit, then fetches the slot through the single read port of the
// slot store and takes it (probe, slot fetch, write back). After reset the
// presence map is cleared one entry a cycle with req_tready low. The result sits
// in an output register; the next item is accepted while it waits, and the block
// stalls only when a new result is ready and the previous one has not been taken.
`default_nettype none

module random_draw_index_pool_unit #(
   parameter int ROW_COUNT   = rdip_pkg::DEF_ROW_COUNT,
   parameter int COL_COUNT   = rdip_pkg::DEF_COL_COUNT,
   parameter int LAYER_COUNT = rdip_pkg::DEF_LAYER_COUNT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // [1:0] action
   input  wire  [31:0] req_tdata,   // [3:0] row, [7:4] col, [11:8] layer, [27:12] random_value
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [31:0] rsp_tdata    // [3:0] out_row, [7:4] out_col, [11:8] out_layer,
                                    // [24:12] remaining
);
   import rdip_pkg::*;

   localparam logic [COORD_W:0] ROW_LIM   = (COORD_W+1)'(ROW_COUNT);
   localparam logic [COORD_W:0] COL_LIM   = (COORD_W+1)'(COL_COUNT);
   localparam logic [COORD_W:0] LAYER_LIM = (COORD_W+1)'(LAYER_COUNT);

   // sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_PROBE  = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_GET    = 4'd5;
   localparam logic [3:0] S_GOT    = 4'd6;
   localparam logic [3:0] S_TAKE   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // storage
   logic [KEY_W-1:0] store_mem [POOL_DEPTH];
   logic [KEY_W-1:0] slot_mem  [POOL_DEPTH];
   logic             pres_mem  [POOL_DEPTH];

   logic [3:0]         state_ff, state_in;
   logic [KEY_W-1:0]   clr_ff, clr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         act_ff, act_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [RAND_W-1:0]  rnd_ff, rnd_in;
   logic               range_ff, range_in;
   logic [KEY_W-1:0]   slot_ff, slot_in;
   logic [KEY_W-1:0]   moved_ff, moved_in;
   logic [KEY_W-1:0]   gone_ff, gone_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   logic [KEY_W-1:0]   store_rd_ff;
   logic [KEY_W-1:0]   slot_rd_ff;
   logic               pres_rd_ff;

   logic               store_we, slot_we, pres_we;
   logic [KEY_W-1:0]   store_wa, store_wd, store_ra;
   logic [KEY_W-1:0]   slot_wa, slot_wd;
   logic [KEY_W-1:0]   pres_wa;
   logic               pres_wd;

   logic               req_fire;
   logic               out_free;
   logic               mod_start;
   mod_status_type     mod_status;
   logic [KEY_W-1:0]   mod_rem;
   logic [KEY_W-1:0]   last_slot;
   logic [KEY_W-1:0]   res_key;
   logic [COORD_W-1:0] in_row, in_col, in_layer;

   assign in_row    = req_tdata[3:0];
   assign in_col    = req_tdata[7:4];
   assign in_layer  = req_tdata[11:8];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_slot  = KEY_W'(count_ff - 1'b1);
   assign mod_start  = (state_ff == S_DECIDE) && (act_ff == ACT_DRAW) && (count_ff != '0);

   rdip_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (count_ff),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   // sequencer and memory port control
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      act_in    = act_ff;
      key_in    = key_ff;
      rnd_in    = rnd_ff;
      range_in  = range_ff;
      slot_in   = slot_ff;
      moved_in  = moved_ff;
      gone_in   = gone_ff;
      status_in = status_ff;
      store_we  = 1'b0;
      store_wa  = slot_ff;
      store_wd  = moved_ff;
      store_ra  = last_slot;
      slot_we   = 1'b0;
      slot_wa   = moved_ff;
      slot_wd   = slot_ff;
      pres_we   = 1'b0;
      pres_wa   = gone_ff;
      pres_wd   = 1'b0;
      res_key   = '0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            pres_we = 1'b1;
            pres_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == KEY_W'(POOL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_tuser;
               key_in    = {in_row, in_col, in_layer};
               rnd_in    = req_tdata[27:12];
               range_in  = ({1'b0, in_row} < ROW_LIM) && ({1'b0, in_col} < COL_LIM)
                           && ({1'b0, in_layer} < LAYER_LIM);
               status_in = ST_DONE;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            // read presence, reverse map and last slot in parallel
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            moved_in = store_rd_ff;
            unique case (act_ff)
               ACT_INSERT: begin
                  if (!range_ff || pres_rd_ff || count_ff[KEY_W]) begin
                     status_in = ST_REFUSE;
                  end else begin
                     store_we = 1'b1;
                     store_wa = count_ff[KEY_W-1:0];
                     store_wd = key_ff;
                     slot_we  = 1'b1;
                     slot_wa  = key_ff;
                     slot_wd  = count_ff[KEY_W-1:0];
                     pres_we  = 1'b1;
                     pres_wa  = key_ff;
                     pres_wd  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end
               ACT_DRAW: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_DIV;
                  end
               end
               ACT_REMOVE: begin
                  if (!range_ff || !pres_rd_ff || count_ff == '0) begin
                     status_in = ST_REFUSE;
                     state_in  = S_DONE;
                  end else begin
                     slot_in  = slot_rd_ff;
                     gone_in  = key_ff;
                     state_in = S_TAKE;
                  end
               end
               ACT_NONE: begin
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DIV: begin
            if (mod_status.done) begin
               slot_in  = mod_rem;
               state_in = S_GET;
            end
         end
         S_GET: begin
            store_ra = slot_ff;
            state_in = S_GOT;
         end
         S_GOT: begin
            gone_in  = store_rd_ff;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            // move the last entry into the hole and drop the taken key
            store_we = 1'b1;
            slot_we  = 1'b1;
            pres_we  = 1'b1;
            count_in = count_ff - 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               if (act_ff == ACT_DRAW && status_ff == ST_DONE) begin
                  res_key = gone_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               // row lowest, then col, then layer
               rsp_data_in  = {7'd0, count_ff, res_key[COORD_W-1:0],
                               res_key[2*COORD_W-1:COORD_W], res_key[KEY_W-1:2*COORD_W]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item payload and result registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      rnd_ff      <= rnd_in;
      range_ff    <= range_in;
      slot_ff     <= slot_in;
      moved_ff    <= moved_in;
      gone_ff     <= gone_in;
      status_ff   <= status_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   // slot store: one write, one registered read
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      store_rd_ff <= store_mem[store_ra];
   end

   // reverse map: one write, one registered read
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[key_ff];
   end

   // presence map: one write, one registered read
   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_wa] <= pres_wd;
      end
      pres_rd_ff <= pres_mem[key_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
